### design/spm_pkg.sv
// spm_pkg: shared constants and types for the spiral matrix reader.
// Holds the configuration register map and the control bundle passed
// from the sequencer to the top level. No dependencies.
package spm_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_W     = 5;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'd1;

	// Reset value of both dimension registers
	localparam logic [CFG_W-1:0] CFG_DIM_RESET = 5'd16;

	// Per-transfer control from the sequencer
	typedef struct packed {
		logic wr_en;  // load writes the element store
		logic rd_en;  // fetch reads the store and yields a result
		logic last;   // result closes the traversal
		logic idle;   // nothing loaded and nothing emitted
	} spm_cmd_t;

endpackage

### design/spm_store.sv
// spm_store: single-port element store with registered read data.
// Depends on nothing; written on loads, read on fetches.
module spm_store #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8,
	parameter int unsigned DW    = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic          rd_en,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data_s1
);

	logic [DW-1:0] mem [DEPTH];

	// Write and registered read share the one address
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[addr];
		end
	end

endmodule

### design/spm_ctrl.sv
// spm_ctrl: configuration registers, load/emit counters, spiral bounds
// and cursor. Depends on spm_pkg; drives the store address and commands.
module spm_ctrl #(
	parameter int unsigned MAX_ROWS = 16,
	parameter int unsigned MAX_COLS = 16,
	localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS,
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           operation,
	input  logic                           cfg_we,
	input  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spm_pkg::CFG_W-1:0]      cfg_wdata,
	output logic [AW-1:0]                  addr,
	output spm_pkg::spm_cmd_t              cmd
);
	import spm_pkg::*;

	localparam int unsigned CW  = $clog2(DEPTH + 1);
	localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned ERW = $clog2(MAX_ROWS + 1);
	localparam int unsigned ECW = $clog2(MAX_COLS + 1);
	localparam int unsigned MW  = RW + ECW + 1;

	// Spiral side codes
	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// Zero reads as one, anything above the maximum is clamped
	function automatic logic [ERW-1:0] eff_rows_f(input logic [CFG_W-1:0] v);
		if (v == '0) eff_rows_f = ERW'(1);
		else if (int'(v) > int'(MAX_ROWS)) eff_rows_f = ERW'(MAX_ROWS);
		else eff_rows_f = ERW'(v);
	endfunction

	function automatic logic [ECW-1:0] eff_cols_f(input logic [CFG_W-1:0] v);
		if (v == '0) eff_cols_f = ECW'(1);
		else if (int'(v) > int'(MAX_COLS)) eff_cols_f = ECW'(MAX_COLS);
		else eff_cols_f = ECW'(v);
	endfunction

	logic [CFG_W-1:0] num_rows_q, num_cols_q, num_rows_n, num_cols_n;
	logic [CW-1:0]    loaded_q, emitted_q, loaded_n, emitted_n;
	logic [RW-1:0]    top_q, bottom_q, row_q, top_n, bottom_n, row_n;
	logic [CLW-1:0]   left_q, right_q, col_q, left_n, right_n, col_n;
	logic [1:0]       dir_q, dir_n;
	logic [ERW-1:0]   eff_rows, clr_rows;
	logic [ECW-1:0]   eff_cols, clr_cols;
	logic [CW-1:0]    total;
	logic [AW-1:0]    rd_addr;
	logic             idle, cfg_take, loaded_full, do_load, do_fetch, is_last, clear;

	// Effective geometry and item decode
	assign eff_rows    = eff_rows_f(num_rows_q);
	assign eff_cols    = eff_cols_f(num_cols_q);
	assign total       = CW'(eff_rows * eff_cols);
	assign idle        = (loaded_q == '0) && (emitted_q == '0);
	assign cfg_take    = cfg_we && idle;
	assign loaded_full = (loaded_q == total);
	assign do_load     = accept && !operation && !loaded_full;
	assign do_fetch    = accept && operation && loaded_full;
	assign is_last     = (emitted_q == total - CW'(1));
	assign clear       = cfg_take || (do_fetch && is_last);

	// Store address: row-major fill position or spiral cursor
	assign rd_addr = AW'(MW'(row_q) * MW'(eff_cols) + MW'(col_q));
	assign addr    = do_fetch ? rd_addr : loaded_q[AW-1:0];

	assign cmd.wr_en = do_load;
	assign cmd.rd_en = do_fetch;
	assign cmd.last  = is_last;
	assign cmd.idle  = idle;

	// Next configuration; a write only lands while idle
	always_comb begin
		num_rows_n = num_rows_q;
		num_cols_n = num_cols_q;
		if (cfg_take) begin
			case (cfg_index)
				CFG_NUM_ROWS: num_rows_n = cfg_wdata;
				CFG_NUM_COLS: num_cols_n = cfg_wdata;
				default: ;
			endcase
		end
	end

	assign clr_rows = eff_rows_f(num_rows_n);
	assign clr_cols = eff_cols_f(num_cols_n);

	// Cursor step: continue along the side, or close it and turn
	always_comb begin
		loaded_n  = loaded_q;
		emitted_n = emitted_q;
		top_n     = top_q;
		bottom_n  = bottom_q;
		left_n    = left_q;
		right_n   = right_q;
		row_n     = row_q;
		col_n     = col_q;
		dir_n     = dir_q;
		if (clear) begin
			loaded_n  = '0;
			emitted_n = '0;
			top_n     = '0;
			bottom_n  = RW'(clr_rows - ERW'(1));
			left_n    = '0;
			right_n   = CLW'(clr_cols - ECW'(1));
			row_n     = '0;
			col_n     = '0;
			dir_n     = DIR_DOWN;
		end else if (do_load) begin
			loaded_n = loaded_q + CW'(1);
		end else if (do_fetch) begin
			emitted_n = emitted_q + CW'(1);
			case (dir_q)
				DIR_DOWN: begin
					if (row_q < bottom_q) begin
						row_n = row_q + RW'(1);
					end else begin
						left_n = left_q + CLW'(1);
						dir_n  = DIR_RIGHT;
						row_n  = bottom_q;
						col_n  = left_q + CLW'(1);
					end
				end
				DIR_RIGHT: begin
					if (col_q < right_q) begin
						col_n = col_q + CLW'(1);
					end else begin
						bottom_n = bottom_q - RW'(1);
						dir_n    = DIR_UP;
						row_n    = bottom_q - RW'(1);
						col_n    = right_q;
					end
				end
				DIR_UP: begin
					if (row_q > top_q) begin
						row_n = row_q - RW'(1);
					end else begin
						right_n = right_q - CLW'(1);
						dir_n   = DIR_LEFT;
						row_n   = top_q;
						col_n   = right_q - CLW'(1);
					end
				end
				DIR_LEFT: begin
					if (col_q > left_q) begin
						col_n = col_q - CLW'(1);
					end else begin
						top_n = top_q + RW'(1);
						dir_n = DIR_DOWN;
						row_n = top_q + RW'(1);
						col_n = left_q;
					end
				end
				default: ;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CFG_DIM_RESET;
			num_cols_q <= CFG_DIM_RESET;
			loaded_q   <= '0;
			emitted_q  <= '0;
			top_q      <= '0;
			bottom_q   <= RW'(eff_rows_f(CFG_DIM_RESET) - ERW'(1));
			left_q     <= '0;
			right_q    <= CLW'(eff_cols_f(CFG_DIM_RESET) - ECW'(1));
			row_q      <= '0;
			col_q      <= '0;
			dir_q      <= DIR_DOWN;
		end else begin
			num_rows_q <= num_rows_n;
			num_cols_q <= num_cols_n;
			loaded_q   <= loaded_n;
			emitted_q  <= emitted_n;
			top_q      <= top_n;
			bottom_q   <= bottom_n;
			left_q     <= left_n;
			right_q    <= right_n;
			row_q      <= row_n;
			col_q      <= col_n;
			dir_q      <= dir_n;
		end
	end

endmodule

### design/spiral_matrix_reader.sv
// spiral_matrix_reader: loads a matrix row-major, returns it in spiral order.
// Depends on spm_pkg, spm_ctrl and spm_store.
//
//   port group   dir  handshake            payload
//   in           in   in_valid / in_stall  operation, element_in
//   out          out  out_valid / out_stall element_out, last
//   cfg          in   cfg_we               cfg_index, cfg_wdata
//
// One item per cycle is taken while in_stall is low. A fetch result passes
// through the store read register and then the output register. Loads and
// early fetches give no result.
// Reset clears counters and bounds and restores config; the store is kept.
// in_stall rises only when both the read stage and the output register hold
// results and the output side is stalled.
module spiral_matrix_reader #(
	parameter int unsigned MAX_ROWS   = 16,
	parameter int unsigned MAX_COLS   = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic signed [DATA_WIDTH-1:0]  element_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [DATA_WIDTH-1:0]  element_out,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spm_pkg::CFG_W-1:0]     cfg_wdata
);
	import spm_pkg::*;

	localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	spm_cmd_t            cmd;
	logic [AW-1:0]       addr;
	logic [DATA_WIDTH-1:0] rd_data_s1;
	logic                valid_s1, last_s1;
	logic                out_valid_q, last_q;
	logic [DATA_WIDTH-1:0] element_q;
	logic                accept, out_free, s1_move;

	// Handshake
	assign out_free = !out_valid_q || !out_stall;
	assign s1_move  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	spm_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.addr      (addr),
		.cmd       (cmd)
	);

	spm_store #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (DATA_WIDTH)
	) u_store (
		.clk        (clk),
		.wr_en      (cmd.wr_en),
		.rd_en      (cmd.rd_en),
		.addr       (addr),
		.wr_data    (element_in),
		.rd_data_s1 (rd_data_s1)
	);

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= cmd.rd_en;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.rd_en) begin
			last_s1 <= cmd.last;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			element_q <= rd_data_s1;
			last_q    <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign element_out = element_q;
	assign last        = last_q;

	// Checks
	a_cmd_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en || cmd.rd_en) |-> accept)
		else $error("store command without an input transfer");

	a_no_load_and_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.rd_en))
		else $error("load and fetch in the same cycle");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.rd_en && cmd.last) |=> cmd.idle)
		else $error("traversal state not cleared after last element");

	a_fetch_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.rd_en) |=> valid_s1)
		else $error("fetch result lost in read stage");

endmodule

### dv/spiral_matrix_reader_test.sv
// spiral_matrix_reader_test: self-checking bench for the spiral matrix reader.
// Loads matrices row-major, fetches them back and checks order and last flag.
// Depends on spm_pkg and spiral_matrix_reader.
module spiral_matrix_reader_test;
	import spm_pkg::*;

	localparam int IDLE_PCT      = 17;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 40;

	typedef enum logic {OP_LOAD = 1'b0, OP_FETCH = 1'b1} spiral_op_e;

	typedef struct {
		logic signed [31:0] value;
		logic               last;
	} spiral_elem_t;

	// Predicts the spiral walk and holds the results still owed by the block
	class spiral_order_model;
		typedef enum bit [1:0] {WALK_DOWN, WALK_RIGHT, WALK_UP, WALK_LEFT} walk_e;

		bit [4:0]           rows_reg;
		bit [4:0]           cols_reg;
		logic signed [31:0] store [256];
		int                 loaded;
		int                 emitted;
		int                 top_b;
		int                 bot_b;
		int                 left_b;
		int                 right_b;
		int                 cur_r;
		int                 cur_c;
		walk_e              walk;
		spiral_elem_t       owed_q[$];
		int                 mismatches;

		function new();
			rows_reg   = CFG_DIM_RESET;
			cols_reg   = CFG_DIM_RESET;
			mismatches = 0;
			restart();
		endfunction

		// zero counts as one, anything past 16 as 16
		static function int clamp_dim(bit [4:0] v);
			if (v == 0) return 1;
			if (v > 16) return 16;
			return int'(v);
		endfunction

		function int cells();
			return clamp_dim(rows_reg) * clamp_dim(cols_reg);
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void restart();
			loaded  = 0;
			emitted = 0;
			top_b   = 0;
			bot_b   = clamp_dim(rows_reg) - 1;
			left_b  = 0;
			right_b = clamp_dim(cols_reg) - 1;
			cur_r   = 0;
			cur_c   = 0;
			walk    = WALK_DOWN;
		endfunction

		// close the current side, shrink its bound; 1 if the new side is non-empty
		function bit turn();
			case (walk)
				WALK_DOWN: begin
					left_b++;
					walk  = WALK_RIGHT;
					cur_r = bot_b;
					cur_c = left_b;
					return left_b <= right_b;
				end
				WALK_RIGHT: begin
					bot_b--;
					walk  = WALK_UP;
					cur_r = bot_b;
					cur_c = right_b;
					return bot_b >= top_b;
				end
				WALK_UP: begin
					right_b--;
					walk  = WALK_LEFT;
					cur_r = top_b;
					cur_c = right_b;
					return right_b >= left_b;
				end
				default: begin
					top_b++;
					walk  = WALK_DOWN;
					cur_r = top_b;
					cur_c = left_b;
					return top_b <= bot_b;
				end
			endcase
		endfunction

		function void step_cursor();
			int k;
			case (walk)
				WALK_DOWN:  if (cur_r + 1 <= bot_b) begin cur_r++; return; end
				WALK_RIGHT: if (cur_c + 1 <= right_b) begin cur_c++; return; end
				WALK_UP:    if (cur_r - 1 >= top_b) begin cur_r--; return; end
				default:    if (cur_c - 1 >= left_b) begin cur_c--; return; end
			endcase
			for (k = 0; k < 8; k++) begin
				if (turn()) return;
			end
		endfunction

		// register writes only take effect with nothing loaded or emitted
		function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [4:0] val);
			if (loaded != 0 || emitted != 0) return;
			if (idx == CFG_NUM_ROWS) rows_reg = val;
			else cols_reg = val;
			restart();
		endfunction

		function void note_item(spiral_op_e op, logic signed [31:0] data);
			int total;
			int idx;
			spiral_elem_t res;
			total = cells();
			if (op == OP_LOAD) begin
				if (loaded < total) begin
					store[loaded] = data;
					loaded++;
				end
				return;
			end
			// fetch before the matrix is complete: no result
			if (loaded < total) return;
			idx       = cur_r * clamp_dim(cols_reg) + cur_c;
			res.value = store[idx];
			emitted++;
			if (emitted >= total) begin
				res.last = 1'b1;
				restart();
			end else begin
				res.last = 1'b0;
				step_cursor();
			end
			owed_q.push_back(res);
		endfunction

		function void check_result(logic signed [31:0] value, logic last_flag);
			spiral_elem_t want;
			if (owed_q.size() == 0) begin
				$error("result with none owed: element_out=%0d last=%0b", value, last_flag);
				mismatches++;
				return;
			end
			want = owed_q.pop_front();
			if (value !== want.value) begin
				$error("element_out: expected %0d, got %0d", want.value, value);
				mismatches++;
			end
			if (last_flag !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, last_flag);
				mismatches++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   operation;
	logic signed [31:0]     element_in;
	logic                   out_valid;
	logic                   out_stall;
	logic signed [31:0]     element_out;
	logic                   last;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;

	spiral_order_model spiral;
	bit                gaps_on;
	int                items_sent;
	int                quiet_cycles;

	spiral_matrix_reader DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.element_in  (element_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.element_out (element_out),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	// clock: period 12
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// output-side backpressure
	always @(posedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
	end

	// transfer monitor: both sides sampled on the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) spiral.note_item(spiral_op_e'(operation), element_in);
			if (out_valid && !out_stall) spiral.check_result(element_out, last);
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send(input spiral_op_e op, input logic [31:0] data);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		element_in <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// hold off input until every owed result is back, then let the pipe drain
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (spiral.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		spiral.write_reg(idx, val);
	endtask

	task automatic reconfigure(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
		settle();
		if ($urandom_range(1)) begin
			write_reg(CFG_NUM_ROWS, rows);
			write_reg(CFG_NUM_COLS, cols);
		end else begin
			write_reg(CFG_NUM_COLS, cols);
			write_reg(CFG_NUM_ROWS, rows);
		end
		cfg_we <= 1'b0;
	endtask

	// one full matrix: load it, then walk it; noisy adds stray items and busy writes
	task automatic run_matrix(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
	                          input bit noisy);
		int total;
		int j;
		reconfigure(rows, cols);
		total = spiral.cells();
		for (j = 0; j < total; j++) begin
			if (noisy && $urandom_range(99) < 5) send(OP_FETCH, $urandom);
			if (noisy && j > 0 && $urandom_range(99) < 3) begin
				settle();
				write_reg($urandom_range(1) ? CFG_NUM_COLS : CFG_NUM_ROWS,
				          CFG_W'($urandom_range(31)));
				cfg_we <= 1'b0;
			end
			send(OP_LOAD, $urandom);
		end
		for (j = 0; j < total; j++) begin
			// stray loads are only placed before the closing fetch
			if (noisy && $urandom_range(99) < 5) send(OP_LOAD, $urandom);
			send(OP_FETCH, $urandom);
		end
	endtask

	function automatic logic [CFG_W-1:0] pick_dim();
		int r;
		r = $urandom_range(99);
		if (r < 60) return CFG_W'($urandom_range(4, 1));
		if (r < 80) return CFG_W'($urandom_range(16, 5));
		if (r < 90) return '0;
		return CFG_W'($urandom_range(31, 16));
	endfunction

	initial begin
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] cols;
		int               phase;
		int               start_count;

		spiral       = new();
		gaps_on      = 1'b1;
		items_sent   = 0;
		quiet_cycles = 0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		operation  <= OP_LOAD;
		element_in <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_NUM_ROWS;
		cfg_wdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 1x1 via zero-size registers: early fetch, load, load past the end, fetch
		reconfigure('0, '0);
		send(OP_FETCH, 32'h0000_0000);
		send(OP_LOAD, 32'h8000_0000);
		send(OP_LOAD, 32'h7fff_ffff);
		send(OP_FETCH, 32'hffff_ffff);

		// 2x3 turns all four corners; a write partway through loading is dropped
		reconfigure(5'd2, 5'd3);
		send(OP_LOAD, 32'hffff_ffff);
		send(OP_LOAD, 32'h0000_0000);
		settle();
		write_reg(CFG_NUM_ROWS, 5'd31);
		cfg_we <= 1'b0;
		send(OP_LOAD, 32'h5555_5555);
		send(OP_LOAD, 32'haaaa_aaaa);
		send(OP_LOAD, 32'h0000_0001);
		send(OP_LOAD, 32'hffff_fffe);
		send(OP_FETCH, 32'h0);
		send(OP_FETCH, 32'h0);
		send(OP_FETCH, 32'h0);
		send(OP_LOAD, 32'h1234_5678);
		send(OP_FETCH, 32'h0);
		send(OP_FETCH, 32'h0);
		send(OP_FETCH, 32'h0);

		// random matrices, mostly small, with a stretch free of idling
		start_count = items_sent;
		phase = 0;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			gaps_on = !(phase >= 6 && phase < 14);
			rows = pick_dim();
			cols = pick_dim();
			if (spiral_order_model::clamp_dim(rows) * spiral_order_model::clamp_dim(cols) > 40)
				cols = CFG_W'($urandom_range(2));
			run_matrix(rows, cols, $urandom_range(99) < 70);
			phase++;
		end

		// full size once, without idling; then 1x16 and 3x5 with idling and noise
		gaps_on = 1'b0;
		run_matrix(5'd16, 5'd16, 1'b0);
		gaps_on = 1'b1;
		run_matrix(5'd1, 5'd16, 1'b1);
		run_matrix(5'd3, 5'd5, 1'b1);

		settle();
		repeat (8) @(posedge clk);
		if (spiral.mismatches == 0 && spiral.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
